// ===== hw/rtl/lpht_pkg.sv =====
// shared types and codes for the linear probing hash table
package lpht_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PRB_RD,
        S_PRB_WT,
        S_PRB_CHK,
        S_INS_WR,
        S_SH_RD,
        S_SH_WT,
        S_SH_CHK,
        S_SH_MOVE,
        S_SH_END,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic clr_step;
        logic clr_start;
        logic prb_start;
        logic prb_rd;
        logic prb_adv;
        logic ins_wr;
        logic sh_start;
        logic sh_rd;
        logic sh_adv;
        logic sh_move;
        logic sh_end;
        logic set_result;
        t_status status;
        logic count_inc;
        logic count_dec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic slot_valid;
        logic key_match;
        logic prb_last;
        logic at_limit;
        logic count_zero;
        logic sh_last;
        logic sh_move_ok;
        t_req req;
    } t_sts;

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// generic single port ram with registered read
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lpht_datapath.sv =====
// slot memory, probe pointers, counters and result registers
module lpht_datapath #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpht_pkg::t_cmd    i_cmd,
    output lpht_pkg::t_sts    o_sts,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_load_shift,
    input  logic [1:0]        i_req_type,
    input  logic [31:0]       i_key,
    input  logic [31:0]       i_value,
    input  logic [31:0]       i_hash,
    output logic [1:0]        o_status,
    output logic [31:0]       o_found_value,
    output logic [10:0]       o_entry_count
);
    import lpht_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = IW + 1;
    localparam int SW = 1 + KEY_BITS + VALUE_BITS + IW;

    logic [1:0]            r_load_shift;
    t_req                  r_req;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [IW-1:0]         r_home;
    logic [IW-1:0]         r_j, n_j;
    logic [IW-1:0]         r_prev;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_clr;
    logic [1:0]            r_status;
    logic [31:0]           r_fv;

    logic                  ram_we;
    logic [IW-1:0]         ram_addr;
    logic [SW-1:0]         ram_wdata, ram_rdata;
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [IW-1:0]         rd_home;
    logic [CW-1:0]         limit;
    logic                  mv;

    assign {rd_valid, rd_key, rd_value, rd_home} = ram_rdata;

    lpht_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_j = r_j + IW'(1);
        ram_we = 1'b0;
        ram_addr = r_j;
        ram_wdata = '0;
        if (i_cmd.clr_step) begin
            ram_we = 1'b1;
            ram_addr = r_clr;
        end else if (i_cmd.ins_wr) begin
            ram_we = 1'b1;
            ram_wdata = {1'b1, r_key, r_value, r_home};
        end else if (i_cmd.sh_move) begin
            ram_we = 1'b1;
            ram_addr = r_prev;
            ram_wdata = {1'b1, rd_key, rd_value, rd_home};
        end else if (i_cmd.sh_end) begin
            ram_we = 1'b1;
            ram_addr = r_prev;
        end
    end

    // entry at j may move back to prev
    always_comb begin
        if (r_prev < r_j) begin
            mv = (rd_home <= r_prev) || (rd_home > r_j);
        end else begin
            mv = (rd_home <= r_prev) && (rd_home > r_j);
        end
    end

    assign limit = CW'(CAPACITY) >> r_load_shift;

    assign o_sts.clr_last   = (r_clr == '1);
    assign o_sts.slot_valid = rd_valid;
    assign o_sts.key_match  = (rd_key == r_key);
    assign o_sts.prb_last   = (r_n == CW'(CAPACITY - 1));
    assign o_sts.at_limit   = ((r_count + CW'(1)) > limit);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.sh_last    = (r_n == CW'(CAPACITY - 1));
    assign o_sts.sh_move_ok = mv;
    assign o_sts.req        = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_shift <= 2'd1;
            r_count <= '0;
            r_clr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_load_shift <= i_cfg_load_shift;
            end
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= t_req'(i_req_type);
            r_key <= i_key[KEY_BITS-1:0];
            r_value <= i_value[VALUE_BITS-1:0];
            r_home <= i_hash[IW-1:0];
        end
        if (i_cmd.prb_start) begin
            r_j <= r_home;
            r_n <= '0;
        end else if (i_cmd.prb_adv) begin
            r_j <= n_j;
            r_n <= r_n + CW'(1);
        end else if (i_cmd.sh_start) begin
            r_prev <= r_j;
            r_j <= n_j;
            r_n <= CW'(1);
        end else if (i_cmd.sh_adv) begin
            r_j <= n_j;
            r_n <= r_n + CW'(1);
        end
        if (i_cmd.sh_move) begin
            r_prev <= r_j;
        end
        if (i_cmd.set_result) begin
            r_status <= i_cmd.status;
            if (i_cmd.status == ST_OK && r_req == REQ_FIND) begin
                r_fv <= 32'(rd_value);
            end else begin
                r_fv <= '0;
            end
        end
    end

    assign o_status = r_status;
    assign o_found_value = r_fv;
    assign o_entry_count = 11'(r_count);
endmodule

// ===== hw/rtl/lpht_ctrl.sv =====
// request sequencer for the clearing pass, probe, insert and backward shift
module lpht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  lpht_pkg::t_sts i_sts,
    output lpht_pkg::t_cmd o_cmd
);
    import lpht_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_PRB_RD;
            S_PRB_RD: begin
                if (i_sts.req == REQ_NONE ||
                    (i_sts.req == REQ_INSERT && i_sts.at_limit) ||
                    (i_sts.req == REQ_REMOVE && i_sts.count_zero)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PRB_WT;
                end
            end
            S_PRB_WT: n_state = S_PRB_CHK;
            S_PRB_CHK: begin
                if (!i_sts.slot_valid) begin
                    n_state = (i_sts.req == REQ_INSERT) ? S_INS_WR : S_DONE;
                end else if (i_sts.key_match) begin
                    n_state = (i_sts.req == REQ_REMOVE) ? S_SH_WT : S_DONE;
                end else if (i_sts.prb_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PRB_WT;
                end
            end
            S_INS_WR: n_state = S_DONE;
            S_SH_RD: n_state = S_SH_WT;
            S_SH_WT: n_state = S_SH_CHK;
            S_SH_CHK: begin
                if (!i_sts.slot_valid) begin
                    n_state = S_SH_END;
                end else if (i_sts.sh_move_ok) begin
                    n_state = S_SH_MOVE;
                end else if (i_sts.sh_last) begin
                    n_state = S_SH_END;
                end else begin
                    n_state = S_SH_WT;
                end
            end
            S_SH_MOVE: n_state = i_sts.sh_last ? S_SH_END : S_SH_WT;
            S_SH_END: n_state = S_DONE;
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.status = ST_MISS;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load_req = i_valid;
            end
            S_PRB_RD: begin
                o_cmd.prb_start = 1'b1;
                o_cmd.set_result = 1'b1;
                o_cmd.status = (i_sts.req == REQ_INSERT) ? ST_LIMIT : ST_MISS;
            end
            S_PRB_WT: ;
            S_PRB_CHK: begin
                o_cmd.set_result = 1'b1;
                if (!i_sts.slot_valid) begin
                    o_cmd.status = (i_sts.req == REQ_INSERT) ? ST_OK : ST_MISS;
                end else if (i_sts.key_match) begin
                    o_cmd.status = (i_sts.req == REQ_INSERT) ? ST_MISS : ST_OK;
                    o_cmd.sh_start = (i_sts.req == REQ_REMOVE);
                end else begin
                    o_cmd.prb_adv = 1'b1;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                o_cmd.count_inc = 1'b1;
            end
            S_SH_RD, S_SH_WT: ;
            S_SH_CHK: begin
                if (i_sts.slot_valid && !i_sts.sh_move_ok && !i_sts.sh_last) begin
                    o_cmd.sh_adv = 1'b1;
                end
            end
            S_SH_MOVE: begin
                o_cmd.sh_move = 1'b1;
                o_cmd.sh_adv = 1'b1;
            end
            S_SH_END: begin
                o_cmd.sh_end = 1'b1;
                o_cmd.count_dec = 1'b1;
            end
            S_DONE: o_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready outside idle");
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_DONE)) else $error("result outside done");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.ins_wr, o_cmd.sh_move, o_cmd.sh_end, o_cmd.clr_step}) <= 1)
        else $error("multiple ram writes");
    a_inc_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.count_inc && o_cmd.count_dec)) else $error("count inc and dec");
`endif
endmodule

// ===== hw/rtl/linear_probe_hash_table_core.sv =====
// top level of the linear probing hash table
// One request at a time. A request walks its probe chain through the single slot
// memory port one slot at a time, with a wait state and a check state per slot;
// an insert adds a write state, and a remove adds a backward shift that walks
// further slots the same way, with a move state per move and an end state to
// close the last hole. The result is held in the done state until it is taken.
// After reset, a clearing pass writes every slot of the slot memory before
// the first beat is taken.
module linear_probe_hash_table_core #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_load_shift,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    input  logic [31:0] i_hash,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_value,
    output logic [10:0] o_entry_count
);
    import lpht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpht_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    lpht_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_load_shift(i_cfg_load_shift),
        .i_req_type      (i_req_type),
        .i_key           (i_key),
        .i_value         (i_value),
        .i_hash          (i_hash),
        .o_status        (o_status),
        .o_found_value   (o_found_value),
        .o_entry_count   (o_entry_count)
    );
endmodule

// ===== tb/tb_linear_probe_hash_table_core.sv =====
// testbench for the hash table core: directed table plus random traffic vs a predictor
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;
    import lpht_pkg::*;

    localparam int CAP = 1024;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        t_req        req;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] hash;
    } t_beat_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_value;
        logic [10:0] entry_count;
    } t_beat_out;

    typedef struct {
        t_beat_in  stim;
        logic      has_expect;
        t_beat_out want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_load_shift = 2'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = 2'd0;
    logic [31:0] i_key = 32'd0;
    logic [31:0] i_value = 32'd0;
    logic [31:0] i_hash = 32'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_found_value;
    logic [10:0] o_entry_count;

    linear_probe_hash_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_load_shift(i_cfg_load_shift),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_key(i_key), .i_value(i_value), .i_hash(i_hash),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_found_value(o_found_value), .o_entry_count(o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic        tbl_used [CAP];
    logic [31:0] tbl_key [CAP];
    logic [31:0] tbl_val [CAP];
    logic [9:0]  tbl_home [CAP];
    int          tbl_count;
    logic [1:0]  tbl_shift;

    t_beat_out pending_results[$];
    int  fail_count = 0;
    int  quiet_cycles = 0;
    logic rx_idle_on = 1'b1;
    logic tx_idle_on = 1'b1;
    logic [31:0] live_keys[$];

    function automatic int locate_key(logic [31:0] k, logic [9:0] home);
        int j;
        j = home;
        for (int n = 0; n < CAP && tbl_used[j]; n++) begin
            if (tbl_key[j] == k) return j;
            j = (j + 1) % CAP;
        end
        return -1;
    endfunction

    function automatic void close_gap(int gap);
        int prev;
        int j;
        int h;
        logic mv;
        prev = gap;
        j = (prev + 1) % CAP;
        for (int n = 1; n < CAP && tbl_used[j]; n++) begin
            h = tbl_home[j];
            mv = (prev < j && (h <= prev || h > j)) || (prev > j && (h <= prev && h > j));
            if (mv) begin
                tbl_key[prev] = tbl_key[j];
                tbl_val[prev] = tbl_val[j];
                tbl_home[prev] = tbl_home[j];
                prev = j;
            end
            j = (j + 1) % CAP;
        end
        tbl_used[prev] = 1'b0;
    endfunction

    function automatic t_beat_out apply_request(t_beat_in b);
        t_beat_out r;
        logic [9:0] home;
        int at;
        int j;
        home = b.hash[9:0];
        r.status = ST_MISS;
        r.found_value = 32'd0;
        case (b.req)
            REQ_INSERT: begin
                if (tbl_count + 1 > (CAP >> tbl_shift)) begin
                    r.status = ST_LIMIT;
                end else if (locate_key(b.key, home) < 0) begin
                    j = home;
                    while (tbl_used[j]) j = (j + 1) % CAP;
                    tbl_used[j] = 1'b1;
                    tbl_key[j] = b.key;
                    tbl_val[j] = b.value;
                    tbl_home[j] = home;
                    tbl_count++;
                    r.status = ST_OK;
                end
            end
            REQ_FIND: begin
                at = locate_key(b.key, home);
                if (at >= 0) begin
                    r.status = ST_OK;
                    r.found_value = tbl_val[at];
                end
            end
            REQ_REMOVE: begin
                at = (tbl_count != 0) ? locate_key(b.key, home) : -1;
                if (at >= 0) begin
                    close_gap(at);
                    tbl_count--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.entry_count = tbl_count[10:0];
        return r;
    endfunction

    // result side: random stall, compare against oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    t_beat_out w;
                    w = pending_results.pop_front();
                    if (o_status !== w.status) begin
                        $error("status exp %0d got %0d", w.status, o_status);
                        fail_count++;
                    end
                    if (o_found_value !== w.found_value) begin
                        $error("found_value exp %h got %h", w.found_value, o_found_value);
                        fail_count++;
                    end
                    if (o_entry_count !== w.entry_count) begin
                        $error("entry_count exp %0d got %0d", w.entry_count, o_entry_count);
                        fail_count++;
                    end
                end
            end
            i_ready <= !(rx_idle_on && $urandom_range(99) < 17);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic set_load_shift(logic [1:0] s);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_load_shift <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tbl_shift = s;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one beat: optional random gap, hold until accepted
    task automatic send_beat(t_beat_in b, logic has_expect, t_beat_out want);
        t_beat_out p;
        while (tx_idle_on && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= b.req;
        i_key <= b.key;
        i_value <= b.value;
        i_hash <= b.hash;
        do @(posedge i_clk); while (!o_ready);
        p = apply_request(b);
        if (has_expect && p != want) begin
            $error("table row exp %p predictor %p", want, p);
            fail_count++;
        end
        pending_results.push_back(p);
    endtask

    function automatic t_beat_in random_beat(int key_span, int hash_span);
        t_beat_in b;
        int sel;
        sel = $urandom_range(99);
        b.req = sel < 45 ? REQ_INSERT : sel < 75 ? REQ_FIND : sel < 97 ? REQ_REMOVE : REQ_NONE;
        if (live_keys.size() != 0 && $urandom_range(1))
            b.key = live_keys[$urandom_range(live_keys.size() - 1)];
        else
            b.key = $urandom_range(1) ? $urandom_range(key_span) : $urandom;
        b.value = $urandom;
        b.hash = {$urandom} & ~32'd1023 | (b.key * 7 % (hash_span + 1)) % CAP;
        if ($urandom_range(9) == 0) b.hash[9:0] = 10'($urandom);
        if (b.req == REQ_INSERT && live_keys.size() < 64) live_keys.push_back(b.key);
        return b;
    endfunction

    t_row rows[$];
    t_beat_out zero_out;

    initial begin
        t_row row;
        t_beat_in b;
        for (int i = 0; i < CAP; i++) tbl_used[i] = 1'b0;
        tbl_count = 0;
        tbl_shift = 2'd1;
        zero_out = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;

        // directed rows: empty table, extremes, collisions, wrap, ignored type
        row.has_expect = 1'b1;
        row.stim = '{REQ_FIND, 32'd0, 32'd0, 32'd0};
        row.want = '{ST_MISS, 32'd0, 11'd0}; rows.push_back(row);
        row.stim = '{REQ_REMOVE, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF};
        row.want = '{ST_MISS, 32'd0, 11'd0}; rows.push_back(row);
        row.stim = '{REQ_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        row.want = '{ST_MISS, 32'd0, 11'd0}; rows.push_back(row);
        row.stim = '{REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        row.want = '{ST_OK, 32'd0, 11'd1}; rows.push_back(row);
        row.stim = '{REQ_INSERT, 32'hFFFFFFFF, 32'h1234, 32'hFFFFFFFF};
        row.want = '{ST_MISS, 32'd0, 11'd1}; rows.push_back(row);
        row.stim = '{REQ_FIND, 32'hFFFFFFFF, 32'd0, 32'h000003FF};
        row.want = '{ST_OK, 32'hFFFFFFFF, 11'd1}; rows.push_back(row);
        row.has_expect = 1'b0;
        // same home at the top slot: wraps to 0 and 1
        row.stim = '{REQ_INSERT, 32'd0, 32'hA5A5A5A5, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_INSERT, 32'd1, 32'h5A5A5A5A, 32'h800003FF}; rows.push_back(row);
        row.stim = '{REQ_INSERT, 32'd2, 32'h0000FFFF, 32'h00000000}; rows.push_back(row);
        row.stim = '{REQ_FIND, 32'd1, 32'd0, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_REMOVE, 32'hFFFFFFFF, 32'd0, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_FIND, 32'd1, 32'd0, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_FIND, 32'd2, 32'd0, 32'h00000000}; rows.push_back(row);
        row.stim = '{REQ_REMOVE, 32'd7, 32'd0, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_REMOVE, 32'd0, 32'd0, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_REMOVE, 32'd1, 32'd0, 32'h000003FF}; rows.push_back(row);
        row.stim = '{REQ_REMOVE, 32'd2, 32'd0, 32'h00000000}; rows.push_back(row);
        row.stim = '{REQ_FIND, 32'hAAAAAAAA, 32'd0, 32'h55555555}; rows.push_back(row);
        foreach (rows[i]) send_beat(rows[i].stim, rows[i].has_expect, rows[i].want);
        drain();

        // fill to the limit with load shift 3, then hit the limit
        set_load_shift(2'd3);
        for (int i = 0; i < 130; i++) begin
            b = '{REQ_INSERT, 32'h1000 + i, $urandom, $urandom_range(3) * 256 + i % 4};
            send_beat(b, 1'b0, zero_out);
        end
        drain();

        // long stretch without idling, random traffic at load shift 0 over a narrow hash span
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        set_load_shift(2'd0);
        for (int i = 0; i < 200; i++) send_beat(random_beat(300, 40), 1'b0, zero_out);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        drain();

        set_load_shift(2'd2);
        for (int i = 0; i < 375; i++) send_beat(random_beat(400, 60), 1'b0, zero_out);
        drain();
        set_load_shift(2'd1);
        for (int i = 0; i < 375; i++) send_beat(random_beat(2000, 1023), 1'b0, zero_out);
        drain();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/lpht_datapath.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/linear_probe_hash_table_core.sv
tb/tb_linear_probe_hash_table_core.sv
